/* hw/rtl/hlscon_pkg.sv */
// ----------------------------------------------------------------------------
// hlscon_pkg
// Shared types and constants of the HLS text contrast adjuster.
// ----------------------------------------------------------------------------
package hlscon_pkg;

  // lightness / saturation unit is 1/4096, hue unit is 1/16 degree
  localparam logic [12:0]        LightOne  = 13'd4096;
  localparam logic [12:0]        LightHalf = 13'd2048;
  localparam logic signed [14:0] HueFull   = 15'sd5760;
  localparam logic signed [14:0] HueThird  = 15'sd1920;
  localparam logic signed [14:0] HueSixth  = 15'sd960;
  localparam logic signed [14:0] HueFour   = 15'sd3840;
  localparam logic signed [14:0] HueHalf   = 15'sd2880;
  localparam logic [11:0]        BaseGreen = 12'd1920;
  localparam logic [11:0]        BaseBlue  = 12'd3840;

  localparam logic [12:0]  ContrastReset = 13'd1638;
  localparam int unsigned  DivSteps      = 13;  // quotient bits of the divider
  localparam int unsigned  QueueDepth    = 4;

  // queue entry: classified color pair
  typedef struct packed {
    logic [12:0] back_light;
    logic [12:0] fore_light;
    logic        gray;
    logic [19:0] sat_num;
    logic [7:0]  sat_den;
    logic [19:0] hue_num;
    logic [7:0]  hue_den;
    logic        hue_neg;
    logic [11:0] hue_base;
  } front_t;

  // fields riding alongside the dividers
  typedef struct packed {
    logic [12:0] back_light;
    logic [12:0] fore_light;
    logic        gray;
    logic        hue_neg;
    logic [11:0] hue_base;
  } side_t;

  typedef struct packed {
    logic [7:0]  rem;
    logic [19:0] num;
    logic [12:0] quo;
    logic [7:0]  den;
  } div_stage_t;

endpackage

/* hw/rtl/hlscon_div.sv */
// ----------------------------------------------------------------------------
// hlscon_div
// Pipelined restoring divider, one quotient bit per stage, 20/8 bits.
// ----------------------------------------------------------------------------
module hlscon_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [19:0] dividend_i,
  input  logic [7:0]  divisor_i,
  output logic [12:0] quo_o,
  output logic [7:0]  rem_o
);

  hlscon_pkg::div_stage_t st_q [1:hlscon_pkg::DivSteps];
  hlscon_pkg::div_stage_t st0;

  function automatic hlscon_pkg::div_stage_t step(hlscon_pkg::div_stage_t s);
    logic [8:0]             t;
    hlscon_pkg::div_stage_t r;
    r     = s;
    t     = {s.rem, s.num[19]};
    r.num = {s.num[18:0], 1'b0};
    if (t >= {1'b0, s.den}) begin
      r.rem = 8'(t - {1'b0, s.den});
      r.quo = {s.quo[11:0], 1'b1};
    end else begin
      r.rem = t[7:0];
      r.quo = {s.quo[11:0], 1'b0};
    end
    return r;
  endfunction

  // quotient fits 13 bits, so the top 7 dividend bits start as remainder
  always_comb begin
    st0.rem = {1'b0, dividend_i[19:13]};
    st0.num = {dividend_i[12:0], 7'd0};
    st0.quo = '0;
    st0.den = divisor_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[1] <= step(st0);
      for (int i = 2; i <= int'(hlscon_pkg::DivSteps); i++) begin
        st_q[i] <= step(st_q[i-1]);
      end
    end
  end

  assign quo_o = st_q[hlscon_pkg::DivSteps].quo;
  assign rem_o = st_q[hlscon_pkg::DivSteps].rem;

endmodule

/* hw/rtl/hlscon_queue.sv */
// ----------------------------------------------------------------------------
// hlscon_queue
// Small FIFO between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module hlscon_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  hlscon_pkg::front_t push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output hlscon_pkg::front_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(hlscon_pkg::QueueDepth);

  hlscon_pkg::front_t mem_q [hlscon_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != (PtrW+1)'(hlscon_pkg::QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? PtrW'(wr_q + 1'b1) : wr_q;
    rd_d  = pop  ? PtrW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = (PtrW+1)'(cnt_q + 1'b1);
    if (!push && pop) cnt_d = (PtrW+1)'(cnt_q - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

/* hw/rtl/hlscon_front.sv */
// ----------------------------------------------------------------------------
// hlscon_front
// Registers a color pair and classifies it: lightness, divider operands, hue sector.
// ----------------------------------------------------------------------------
module hlscon_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [47:0]        in_data_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output hlscon_pkg::front_t q_data_o
);

  logic [47:0] pix_q;
  logic        valid_q;

  // floor(x/255) while the 5-bit result holds it, i.e. for x below 8160
  function automatic logic [4:0] div255(logic [12:0] x);
    logic [13:0] t;
    t = 14'(x) + 14'(x[12:8]) + 14'd1;
    return t[12:8];
  endfunction

  function automatic logic [12:0] light(logic [8:0] sum);
    logic [12:0] s8;
    s8 = {1'b0, sum, 3'b000};
    return 13'(s8 + 13'(div255(s8)));
  endfunction

  logic [7:0] br, bg, bb, fr, fg, fb;
  logic [7:0] bmx, bmn, fmx, fmn, fd, mag;
  logic [8:0] bsum, fsum, diff;

  assign in_ready_o = !valid_q || q_ready_i;
  assign q_valid_o  = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (in_ready_o) valid_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) pix_q <= in_data_i;
  end

  always_comb begin
    {fb, fg, fr, bb, bg, br} = pix_q;
    bmx = (br > bg) ? br : bg;
    bmx = (bb > bmx) ? bb : bmx;
    bmn = (br < bg) ? br : bg;
    bmn = (bb < bmn) ? bb : bmn;
    fmx = (fr > fg) ? fr : fg;
    fmx = (fb > fmx) ? fb : fmx;
    fmn = (fr < fg) ? fr : fg;
    fmn = (fb < fmn) ? fb : fmn;
    bsum = {1'b0, bmx} + {1'b0, bmn};
    fsum = {1'b0, fmx} + {1'b0, fmn};
    fd   = fmx - fmn;

    q_data_o.back_light = light(bsum);
    q_data_o.fore_light = light(fsum);
    q_data_o.gray       = (fmx == fmn);
    q_data_o.sat_num    = {fd, 12'd0};
    q_data_o.sat_den    = (fsum <= 9'd255) ? fsum[7:0] : 8'(9'd510 - fsum);
    q_data_o.hue_den    = fd;

    // red wins ties, then green
    if (fr == fmx) begin
      diff = {1'b0, fg} - {1'b0, fb};
      q_data_o.hue_base = '0;
    end else if (fg == fmx) begin
      diff = {1'b0, fb} - {1'b0, fr};
      q_data_o.hue_base = hlscon_pkg::BaseGreen;
    end else begin
      diff = {1'b0, fr} - {1'b0, fg};
      q_data_o.hue_base = hlscon_pkg::BaseBlue;
    end
    q_data_o.hue_neg = diff[8];
    mag              = diff[8] ? 8'(-diff) : diff[7:0];
    q_data_o.hue_num = ({2'b0, mag, 10'd0}) - ({6'b0, mag, 6'd0});  // mag * 960
  end

endmodule

/* hw/rtl/hlscon_back.sv */
// ----------------------------------------------------------------------------
// hlscon_back
// Saturation and hue division, lightness choice, and HLS to RGB conversion.
// ----------------------------------------------------------------------------
module hlscon_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  hlscon_pkg::front_t q_data_i,
  input  logic [12:0]        contrast_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [23:0]        out_data_o
);

  localparam int unsigned N = hlscon_pkg::DivSteps;

  logic en;
  logic [N:1] dv_q;
  hlscon_pkg::side_t sd_q [1:N];
  hlscon_pkg::side_t side0;
  logic [12:0] sat_quo, hue_quo;
  logic [7:0]  sat_rem, hue_rem;

  logic        a_valid_q, b_valid_q, c_valid_q, o_valid_q;
  logic [12:0] a_light_q, a_sat_q, a_hue_q, b_light_q, b_hue_q, c_light_q;
  logic        a_gray_q, b_gray_q, c_gray_q;
  logic [25:0] b_m1_q, b_m2_q;
  logic [35:0] c_num_q [3];
  logic [23:0] o_data_q;

  assign en          = !o_valid_q || out_ready_i;
  assign q_ready_o   = en;
  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_data_q;

  always_comb begin
    side0.back_light = q_data_i.back_light;
    side0.fore_light = q_data_i.fore_light;
    side0.gray       = q_data_i.gray;
    side0.hue_neg    = q_data_i.hue_neg;
    side0.hue_base   = q_data_i.hue_base;
  end

  hlscon_div u_sat_div (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (q_data_i.sat_num),
    .divisor_i  (q_data_i.sat_den),
    .quo_o      (sat_quo),
    .rem_o      (sat_rem)
  );

  hlscon_div u_hue_div (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (q_data_i.hue_num),
    .divisor_i  (q_data_i.hue_den),
    .quo_o      (hue_quo),
    .rem_o      (hue_rem)
  );

  // ---- stage A: lightness choice, saturation cap, hue assembly
  logic signed [14:0] up, lo, nl_s, hue_s;
  logic [12:0]        nl, lim, fs;
  hlscon_pkg::side_t  sa;

  always_comb begin
    sa    = sd_q[N];
    up    = 15'(sa.back_light) + 15'(contrast_i);
    lo    = 15'(sa.back_light) - 15'(contrast_i);
    if (sa.back_light < sa.fore_light) begin
      nl_s = (up > 15'(hlscon_pkg::LightOne)) ? lo : up;   // light on dark
    end else begin
      nl_s = (lo < 15'sd0) ? up : lo;                      // dark on light
    end
    if (nl_s < 15'sd0) nl = '0;
    else if (nl_s > 15'(hlscon_pkg::LightOne)) nl = hlscon_pkg::LightOne;
    else nl = nl_s[12:0];

    lim = (nl < hlscon_pkg::LightOne - nl) ? 13'({nl[11:0], 1'b0})
                                           : 13'({12'(hlscon_pkg::LightOne - nl), 1'b0});
    fs  = sa.gray ? '0 : sat_quo;
    if (fs > lim) fs = lim;

    // floored division for a negative sector offset
    if (sa.hue_neg) begin
      hue_s = 15'(sa.hue_base) - 15'(hue_quo) - 15'(hue_rem != '0);
    end else begin
      hue_s = 15'(sa.hue_base) + 15'(hue_quo);
    end
    if (hue_s < 15'sd0) hue_s = hue_s + hlscon_pkg::HueFull;
  end

  // ---- stage B: m2 and m1 in 2^-24
  logic [25:0] prod, m2;
  always_comb begin
    prod = 26'(a_light_q) * 26'(a_sat_q);
    if (a_light_q <= hlscon_pkg::LightHalf) begin
      m2 = {1'b0, a_light_q, 12'd0} + prod;
    end else begin
      m2 = {1'b0, a_light_q, 12'd0} + {1'b0, a_sat_q, 12'd0} - prod;
    end
  end

  // ---- stage C: piecewise value numerator per channel
  function automatic logic [35:0] chan_num(logic [25:0] m1, logic [25:0] m2v,
                                           logic [12:0] hue, logic signed [14:0] off);
    logic signed [14:0] h;
    logic [10:0]        x;
    logic [25:0]        dif;
    h = 15'(hue) + off;
    if (h > hlscon_pkg::HueFull) h = h - hlscon_pkg::HueFull;
    if (h < 15'sd0) h = h + hlscon_pkg::HueFull;
    if (h < hlscon_pkg::HueSixth) x = 11'(h);
    else if (h < hlscon_pkg::HueHalf) x = 11'(hlscon_pkg::HueSixth);
    else if (h < hlscon_pkg::HueFour) x = 11'(hlscon_pkg::HueFour - h);
    else x = '0;
    dif = m2v - m1;
    return 36'(m1) * 36'd960 + 36'(dif) * 36'(x);
  endfunction

  // ---- stage D: num*255/(960*2^24) == (num*17) >> 30
  function automatic logic [7:0] chan_out(logic [35:0] num);
    logic [40:0] t;
    t = 41'(num) * 41'd17;
    return (t[40:30] > 11'd255) ? 8'd255 : t[37:30];
  endfunction

  logic [20:0] gprod;
  logic [7:0]  gv;
  assign gprod = 21'(c_light_q) * 21'd255;
  assign gv    = gprod[19:12];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q      <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (en) begin
      dv_q      <= {dv_q[N-1:1], q_valid_i};
      a_valid_q <= dv_q[N];
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      o_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[1] <= side0;
      for (int i = 2; i <= int'(N); i++) sd_q[i] <= sd_q[i-1];
      a_light_q <= nl;
      a_sat_q   <= fs;
      a_hue_q   <= hue_s[12:0];
      a_gray_q  <= (fs == '0);
      b_light_q <= a_light_q;
      b_hue_q   <= a_hue_q;
      b_gray_q  <= a_gray_q;
      b_m2_q    <= m2;
      b_m1_q    <= {a_light_q, 13'd0} - m2;
      c_light_q <= b_light_q;
      c_gray_q  <= b_gray_q;
      c_num_q[0] <= chan_num(b_m1_q, b_m2_q, b_hue_q, hlscon_pkg::HueThird);
      c_num_q[1] <= chan_num(b_m1_q, b_m2_q, b_hue_q, 15'sd0);
      c_num_q[2] <= chan_num(b_m1_q, b_m2_q, b_hue_q, -hlscon_pkg::HueThird);
      if (c_gray_q) begin
        o_data_q <= {gv, gv, gv};
      end else begin
        o_data_q <= {chan_out(c_num_q[2]), chan_out(c_num_q[1]), chan_out(c_num_q[0])};
      end
    end
  end

  a_light_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q |-> a_light_q <= hlscon_pkg::LightOne)
    else $error("chosen lightness above one");

  a_sat_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q |-> ({1'b0, a_sat_q} <= {a_light_q, 1'b0}) &&
                  ({1'b0, a_sat_q} <= {13'(hlscon_pkg::LightOne - a_light_q), 1'b0}))
    else $error("saturation above cap");

  a_m_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> b_m2_q >= b_m1_q)
    else $error("m1 above m2");

endmodule

/* hw/rtl/hls_text_contrast_adjust_top.sv */
// ----------------------------------------------------------------------------
// hls_text_contrast_adjust_top
// Adjusts a text color so its HLS lightness stands a set contrast off a background.
// ----------------------------------------------------------------------------
// Each beat on the slave stream carries a background and a text color; the
// block returns one adjusted text color per beat, in order. It takes one beat
// per clock when the master side keeps tready high; each result passes the
// front register, the queue, the two 13-stage pipelined dividers for text
// saturation and hue offset, then the lightness, m1/m2, channel and output
// stages, in that order. A front stage classifies the pair and computes both
// lightness values, a 4-entry queue decouples it from the arithmetic back
// end, and the back end stalls as a whole only when its output register is
// full and not taken. contrast_amount sits at byte address 0 of the APB port
// and should be written while idle.
// ----------------------------------------------------------------------------
module hls_text_contrast_adjust_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in; tdata: back_red, back_green, back_blue, fore_red, fore_green, fore_blue
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  // stream out; tdata: new_red, new_green, new_blue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [12:0]        contrast_q;
  logic               fq_valid, fq_ready, qb_valid, qb_ready;
  hlscon_pkg::front_t fq_data, qb_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {19'd0, contrast_q} : 32'd0;

  // only register 0 exists; only paddr[2] is decoded, so addresses 1 to 3 alias it and 4 to 7 are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contrast_q <= hlscon_pkg::ContrastReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      contrast_q <= pwdata[12:0];
    end
  end

  hlscon_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .q_valid_o  (fq_valid),
    .q_ready_i  (fq_ready),
    .q_data_o   (fq_data)
  );

  hlscon_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_data),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_data)
  );

  hlscon_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (qb_valid),
    .q_ready_o   (qb_ready),
    .q_data_i    (qb_data),
    .contrast_i  (contrast_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
